// ===== design/jsu_pkg.sv =====
// Shared types and constants for the JSON string unescaper.
package jsu_pkg;

    // Result kinds on the output channel
    localparam logic [1:0] KIND_BYTE  = 2'd0;
    localparam logic [1:0] KIND_DONE  = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    // Command queue geometry
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);

    // Most decoded bytes a single input byte can produce
    localparam int MAXB = 4;
    localparam int NBW  = $clog2(MAXB + 2);

    typedef enum logic [1:0] {
        TAIL_NONE  = 2'd0,
        TAIL_DONE  = 2'd1,
        TAIL_ERROR = 2'd2
    } tail_t;

    // One decoded step: up to four bytes, then an optional done/error result
    typedef struct packed {
        logic [MAXB-1:0][7:0] bytes;
        logic [NBW-1:0]       nbytes;
        tail_t                tail;
    } cmd_t;

endpackage

// ===== design/jsu_front.sv =====
// Front end: byte parser, escape/hex/surrogate decoding and UTF-8 encoding.
module jsu_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic [7:0]    in_byte,
    input  logic          last_in,
    output logic          in_ready,
    input  logic          q_full,
    output logic          push,
    output jsu_pkg::cmd_t cmd
);
    import jsu_pkg::*;

    typedef enum logic [6:0] {
        PH_IDLE = 7'b0000001,
        PH_BODY = 7'b0000010,
        PH_ESC  = 7'b0000100,
        PH_HEX1 = 7'b0001000,
        PH_SBS  = 7'b0010000,
        PH_SU   = 7'b0100000,
        PH_HEX2 = 7'b1000000
    } phase_t;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5c;
    localparam logic [7:0] CH_SLASH = 8'h2f;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_N     = 8'h6e;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_U     = 8'h75;

    localparam logic [5:0]  SUR_HIGH  = 6'b110110;
    localparam logic [5:0]  SUR_LOW   = 6'b110111;
    localparam logic [10:0] PLANE_ONE = 11'h040;

    phase_t      phase_reg, phase_next;
    logic [15:0] acc_reg, acc_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic [9:0]  pend_reg, pend_next;

    logic        accept;
    logic        err, done, emit_raw, emit_cp;
    logic [7:0]  raw_val;
    logic [20:0] cp;
    logic        hex_ok;
    logic [3:0]  hex_val;
    logic [15:0] acc_shift;
    logic [MAXB-1:0][7:0] enc_bytes;
    logic [NBW-1:0]       enc_n;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        hex_ok  = 1'b1;
        hex_val = 4'd0;
        priority if (in_byte >= 8'h30 && in_byte <= 8'h39)
            hex_val = 4'(in_byte - 8'h30);
        else if (in_byte >= 8'h61 && in_byte <= 8'h66)
            hex_val = 4'(in_byte - 8'h57);
        else if (in_byte >= 8'h41 && in_byte <= 8'h46)
            hex_val = 4'(in_byte - 8'h37);
        else
            hex_ok = 1'b0;
    end

    assign acc_shift = {acc_reg[11:0], hex_val};

    always_comb
    begin
        phase_next = phase_reg;
        acc_next   = acc_reg;
        cnt_next   = cnt_reg;
        pend_next  = pend_reg;
        err        = 1'b0;
        done       = 1'b0;
        emit_raw   = 1'b0;
        emit_cp    = 1'b0;
        raw_val    = in_byte;
        cp         = '0;
        unique case (phase_reg)
            PH_BODY:
            begin
                priority if (in_byte == CH_QUOTE)
                begin
                    done       = 1'b1;
                    phase_next = PH_IDLE;
                end
                else if (in_byte < CH_SPACE)
                    err = 1'b1;
                else if (in_byte == CH_BSL)
                    phase_next = PH_ESC;
                else
                    emit_raw = 1'b1;
            end
            PH_ESC:
            begin
                phase_next = PH_BODY;
                emit_raw   = 1'b1;
                priority if (in_byte == CH_QUOTE || in_byte == CH_BSL || in_byte == CH_SLASH)
                    raw_val = in_byte;
                else if (in_byte == CH_B)
                    raw_val = 8'h08;
                else if (in_byte == CH_F)
                    raw_val = 8'h0c;
                else if (in_byte == CH_N)
                    raw_val = 8'h0a;
                else if (in_byte == CH_R)
                    raw_val = 8'h0d;
                else if (in_byte == CH_T)
                    raw_val = 8'h09;
                else if (in_byte == CH_U)
                begin
                    emit_raw   = 1'b0;
                    phase_next = PH_HEX1;
                    acc_next   = '0;
                    cnt_next   = '0;
                end
                else
                begin
                    emit_raw = 1'b0;
                    err      = 1'b1;
                end
            end
            PH_HEX1, PH_HEX2:
            begin
                if (!hex_ok)
                    err = 1'b1;
                else
                begin
                    acc_next = acc_shift;
                    if (cnt_reg != 2'd3)
                        cnt_next = cnt_reg + 2'd1;
                    else
                    begin
                        cnt_next = '0;
                        if (phase_reg == PH_HEX1)
                        begin
                            priority if (acc_shift[15:10] == SUR_HIGH)
                            begin
                                pend_next  = acc_shift[9:0];
                                phase_next = PH_SBS;
                            end
                            else if (acc_shift[15:10] == SUR_LOW)
                                err = 1'b1;
                            else
                            begin
                                emit_cp    = 1'b1;
                                cp         = {5'd0, acc_shift};
                                phase_next = PH_BODY;
                            end
                        end
                        else
                        begin
                            if (acc_shift[15:10] != SUR_LOW)
                                err = 1'b1;
                            else
                            begin
                                // 0x10000 + (high << 10) + low, bits line up directly
                                emit_cp    = 1'b1;
                                cp         = {{1'b0, pend_reg} + PLANE_ONE, acc_shift[9:0]};
                                phase_next = PH_BODY;
                            end
                        end
                    end
                end
            end
            PH_SBS:
            begin
                if (in_byte == CH_BSL)
                    phase_next = PH_SU;
                else
                    err = 1'b1;
            end
            PH_SU:
            begin
                if (in_byte == CH_U)
                begin
                    phase_next = PH_HEX2;
                    acc_next   = '0;
                    cnt_next   = '0;
                end
                else
                    err = 1'b1;
            end
            default:
            begin
                if (in_byte == CH_QUOTE)
                    phase_next = PH_BODY;
                else
                    err = 1'b1;
            end
        endcase

        // input ran out inside the string
        if (!err && last_in && phase_next != PH_IDLE)
            err = 1'b1;

        if (err || phase_next == PH_IDLE)
        begin
            phase_next = PH_IDLE;
            acc_next   = '0;
            cnt_next   = '0;
            pend_next  = '0;
        end
    end

    // UTF-8 encoder
    always_comb
    begin
        enc_bytes = '0;
        priority if (cp[20:7] == '0)
        begin
            enc_n        = NBW'(1);
            enc_bytes[0] = {1'b0, cp[6:0]};
        end
        else if (cp[20:11] == '0)
        begin
            enc_n        = NBW'(2);
            enc_bytes[0] = {3'b110, cp[10:6]};
            enc_bytes[1] = {2'b10, cp[5:0]};
        end
        else if (cp[20:16] == '0)
        begin
            enc_n        = NBW'(3);
            enc_bytes[0] = {4'b1110, cp[15:12]};
            enc_bytes[1] = {2'b10, cp[11:6]};
            enc_bytes[2] = {2'b10, cp[5:0]};
        end
        else
        begin
            enc_n        = NBW'(4);
            enc_bytes[0] = {5'b11110, cp[20:18]};
            enc_bytes[1] = {2'b10, cp[17:12]};
            enc_bytes[2] = {2'b10, cp[11:6]};
            enc_bytes[3] = {2'b10, cp[5:0]};
        end
    end

    always_comb
    begin
        cmd.bytes  = '0;
        cmd.nbytes = '0;
        if (emit_raw)
        begin
            cmd.bytes[0] = raw_val;
            cmd.nbytes   = NBW'(1);
        end
        else if (emit_cp)
        begin
            cmd.bytes  = enc_bytes;
            cmd.nbytes = enc_n;
        end
        if (err)
            cmd.tail = TAIL_ERROR;
        else if (done)
            cmd.tail = TAIL_DONE;
        else
            cmd.tail = TAIL_NONE;
    end

    assign push = accept && (cmd.nbytes != '0 || cmd.tail != TAIL_NONE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            acc_reg   <= '0;
            cnt_reg   <= '0;
            pend_reg  <= '0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            acc_reg   <= acc_next;
            cnt_reg   <= cnt_next;
            pend_reg  <= pend_next;
        end
    end

    a_err_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (push && cmd.tail == TAIL_ERROR) |=> (phase_reg == PH_IDLE && pend_reg == '0))
        else $error("front not idle after error");

    a_surrogate_held: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_SBS && !accept) |=> (phase_reg == PH_SBS && $stable(pend_reg)))
        else $error("pending high surrogate lost while stalled");

endmodule

// ===== design/jsu_queue.sv =====
// Small register FIFO of decoded commands between front and back end.
module jsu_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  jsu_pkg::cmd_t wr_cmd,
    output logic          full,
    input  logic          pop,
    output logic          empty,
    output jsu_pkg::cmd_t head
);
    import jsu_pkg::*;

    cmd_t           q_reg [QDEPTH];
    logic [QAW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCW-1:0] cnt_reg, cnt_next;

    assign full  = (cnt_reg == QCW'(QDEPTH));
    assign empty = (cnt_reg == '0);
    assign head  = q_reg[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
            cnt_next = cnt_reg + QCW'(1);
        else if (pop && !push)
            cnt_next = cnt_reg - QCW'(1);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[wr_ptr_reg] <= wr_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + QAW'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + QAW'(1);
            cnt_reg <= cnt_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && empty))
        else $error("pop from empty queue");

endmodule

// ===== design/jsu_back.sv =====
// Back end: expands queued commands into single results on the output register.
module jsu_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          empty,
    input  jsu_pkg::cmd_t head,
    output logic          pop,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [7:0]    out_byte,
    output logic [1:0]    kind,
    output logic          run_end
);
    import jsu_pkg::*;

    logic [NBW-1:0] idx_reg;
    logic           out_valid_reg;
    logic [7:0]     out_byte_reg;
    logic [1:0]     kind_reg;
    logic           run_end_reg;

    logic [NBW-1:0] total;
    logic           is_last;
    logic           load;
    logic [7:0]     sel_byte;
    logic [1:0]     sel_kind;

    assign total   = head.nbytes + NBW'(head.tail != TAIL_NONE);
    assign is_last = (idx_reg == total - NBW'(1));
    assign load    = !empty && (!out_valid_reg || out_ready);
    assign pop     = load && is_last;

    always_comb
    begin
        if (idx_reg < head.nbytes)
        begin
            sel_byte = head.bytes[idx_reg[$clog2(MAXB)-1:0]];
            sel_kind = KIND_BYTE;
        end
        else
        begin
            sel_byte = '0;
            sel_kind = (head.tail == TAIL_DONE) ? KIND_DONE : KIND_ERROR;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else
        begin
            if (load)
            begin
                out_valid_reg <= 1'b1;
                idx_reg       <= is_last ? '0 : idx_reg + NBW'(1);
            end
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_byte_reg <= sel_byte;
            kind_reg     <= sel_kind;
            run_end_reg  <= is_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign kind      = kind_reg;
    assign run_end   = run_end_reg;

    a_tail_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && kind_reg != KIND_BYTE) |-> (run_end_reg && out_byte_reg == '0))
        else $error("done/error result not last of its run");

    a_idx_reset_on_pop: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (idx_reg == '0))
        else $error("result index not cleared after command");

endmodule

// ===== design/json_string_unescape.sv =====
// Top level of the JSON string unescaper.
//
// Input channel (in_valid/in_ready): one raw byte of a JSON string token per
// transaction, quotes included, last_in set on the final byte of the buffer.
// Output channel (out_valid/out_ready): one result per transaction; kind 0
// carries a decoded byte, kind 1 reports a closed string, kind 2 a malformed
// one. run_end marks the last result produced by a given input byte.
// The front end decodes one byte per cycle while the queue is not full and
// posts zero or one command (up to four UTF-8 bytes plus an optional
// done/error result) into a four-entry queue; the back end drains one
// result per cycle into the output register while it is empty or taken.
// The first result of an input transaction passes through a queue entry
// and then the output register. Throughput is one input byte per cycle
// while out_ready is high and each byte yields at most one result; a byte
// with several results holds the output port; the queue absorbs such bursts.
// When out_ready is low the output register holds, the queue fills and
// in_ready drops once all four entries are taken.
// Reset (rst_n, asynchronous, active low) returns the decoder to idle,
// awaiting an opening quote, and empties the queue.
module json_string_unescape (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       last_in,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic [1:0] kind,
    output logic       run_end
);
    import jsu_pkg::*;

    cmd_t fe_cmd, q_head;
    logic fe_push, q_full, q_empty, be_pop;

    jsu_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_byte  (in_byte),
        .last_in  (last_in),
        .in_ready (in_ready),
        .q_full   (q_full),
        .push     (fe_push),
        .cmd      (fe_cmd)
    );

    jsu_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (fe_push),
        .wr_cmd (fe_cmd),
        .full   (q_full),
        .pop    (be_pop),
        .empty  (q_empty),
        .head   (q_head)
    );

    jsu_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .empty     (q_empty),
        .head      (q_head),
        .pop       (be_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_byte  (out_byte),
        .kind      (kind),
        .run_end   (run_end)
    );

endmodule
